// ----- design/gmt_pkg.sv -----
// shared types and constants for the gossip membership table
package gmt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_W           = 32;
    localparam int SLOT_W          = 6;
    localparam int COUNT_W         = 7;

    typedef enum logic [1:0] {
        ACT_MERGE,
        ACT_HEARTBEAT,
        ACT_OFFLINE,
        ACT_DUMP
    } t_action;

    typedef enum logic [2:0] {
        OC_UPDATED,
        OC_INSERTED,
        OC_IGNORED,
        OC_FULL,
        OC_BAD_INDEX,
        OC_DUMP
    } t_outcome;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_MODIFY,
        ST_DUMP
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [31:0]      generation;
        logic [31:0]      version;
        logic             online;
    } t_entry;

    typedef struct packed {
        logic [1:0]        action;
        logic [KEY_W-1:0]  host_key;
        logic [31:0]       peer_generation;
        logic [31:0]       peer_version;
        logic              peer_online;
        logic [SLOT_W-1:0] entry_index;
    } t_req;

    typedef struct packed {
        logic [2:0]         outcome;
        logic [SLOT_W-1:0]  slot;
        logic [KEY_W-1:0]   out_key;
        logic [31:0]        out_generation;
        logic [31:0]        out_version;
        logic               out_online;
        logic [COUNT_W-1:0] entry_count;
        logic               last;
    } t_rsp;

endpackage

// ----- design/gmt_store.sv -----
// membership table storage: local entry in flops, the rest in a memory with one read port and one write port
module gmt_store import gmt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [KEY_W-1:0] i_cfg_data,
    input  logic [AW-1:0]    i_rd_addr,
    output t_entry           o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  t_entry           i_wr_data
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_e0;
    t_entry r_rd_data;
    logic   r_rd_zero;

    // entry 0 has a defined reset value, so it lives outside the memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0 <= '{key: '0, generation: 32'd1, version: 32'd1, online: 1'b1};
        end else if (i_cfg_we) begin
            r_e0.key <= i_cfg_data;
        end else if (i_wr_en && i_wr_addr == '0) begin
            r_e0 <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_addr != '0) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_zero <= (i_rd_addr == '0);
    end

    assign o_rd_data = r_rd_zero ? r_e0 : r_rd_data;

endmodule

// ----- design/gmt_ctrl.sv -----
// sequencer: scans the table one entry per cycle, compares, updates and emits results
module gmt_ctrl import gmt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  t_req          i_req,
    output logic [AW-1:0] o_rd_addr,
    input  t_entry        i_rd_data,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output t_entry        o_wr_data,
    output logic          o_strobe,
    output t_rsp          o_rsp
);

    t_state          r_state, n_state;
    t_req            r_req, n_req;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_cmp_idx, n_cmp_idx;
    logic            r_pend, n_pend;
    logic [CW-1:0]   r_count, n_count;
    logic            r_stb, n_stb;
    t_rsp            r_rsp, n_rsp;

    logic            hit;
    logic            newer;
    logic            in_range;
    logic            dump_last;
    t_entry          peer;
    t_entry          bumped;

    function automatic t_rsp make_rsp(input t_outcome oc, input logic [CW-1:0] slot,
                                      input t_entry e, input logic [CW-1:0] cnt,
                                      input logic last);
        t_rsp r;
        r.outcome        = oc;
        r.slot           = SLOT_W'(slot);
        r.out_key        = e.key;
        r.out_generation = e.generation;
        r.out_version    = e.version;
        r.out_online     = e.online;
        r.entry_count    = COUNT_W'(cnt);
        r.last           = last;
        return r;
    endfunction

    assign peer = '{key: r_req.host_key, generation: r_req.peer_generation,
                    version: r_req.peer_version, online: r_req.peer_online};

    // compare unit for the merge scan: key match and record age
    assign hit   = r_pend && (i_rd_data.key == r_req.host_key);
    assign newer = (r_req.peer_generation > i_rd_data.generation) ||
                   ((r_req.peer_generation == i_rd_data.generation) &&
                    (r_req.peer_version > i_rd_data.version));

    assign in_range  = {1'b0, i_req.entry_index} < COUNT_W'(r_count);
    assign dump_last = (r_cmp_idx == r_count - CW'(1));

    assign bumped = '{key: i_rd_data.key, generation: i_rd_data.generation,
                      version: i_rd_data.version + 32'd1,
                      online: (t_action'(r_req.action) == ACT_HEARTBEAT)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= CW'(1);
            r_pend  <= 1'b0;
            r_stb   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_stb   <= n_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_rsp     <= n_rsp;
    end

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_idx     = r_idx;
        n_cmp_idx = r_cmp_idx;
        n_pend    = 1'b0;
        n_count   = r_count;
        n_stb     = 1'b0;
        n_rsp     = r_rsp;
        o_rd_addr = r_idx[AW-1:0];
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx[AW-1:0];
        o_wr_data = bumped;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    n_idx = '0;
                    unique case (t_action'(i_req.action))
                        ACT_MERGE:     n_state = ST_SCAN;
                        ACT_HEARTBEAT: n_state = ST_FETCH;
                        ACT_OFFLINE: begin
                            if (in_range) begin
                                n_idx   = CW'(i_req.entry_index);
                                n_state = ST_FETCH;
                            end else begin
                                n_stb = 1'b1;
                                n_rsp = make_rsp(OC_BAD_INDEX, '0, '0, r_count, 1'b1);
                            end
                        end
                        ACT_DUMP:      n_state = ST_DUMP;
                        default:       n_state = ST_IDLE;
                    endcase
                end
            end

            ST_SCAN: begin
                // issue the next read while the previous entry is compared
                if (r_idx < r_count) begin
                    n_idx     = r_idx + CW'(1);
                    n_cmp_idx = r_idx;
                    n_pend    = 1'b1;
                end
                priority if (hit) begin
                    n_state = ST_IDLE;
                    n_pend  = 1'b0;
                    n_stb   = 1'b1;
                    if (newer) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_cmp_idx[AW-1:0];
                        o_wr_data = peer;
                        n_rsp     = make_rsp(OC_UPDATED, r_cmp_idx, peer, r_count, 1'b1);
                    end else begin
                        n_rsp = make_rsp(OC_IGNORED, r_cmp_idx, i_rd_data, r_count, 1'b1);
                    end
                end else if (!r_pend && r_idx == r_count) begin
                    n_state = ST_IDLE;
                    n_stb   = 1'b1;
                    if (r_count < CW'(TABLE_DEPTH)) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_count[AW-1:0];
                        o_wr_data = peer;
                        n_count   = r_count + CW'(1);
                        n_rsp     = make_rsp(OC_INSERTED, r_count, peer,
                                             r_count + CW'(1), 1'b1);
                    end else begin
                        n_rsp = make_rsp(OC_FULL, '0, '0, r_count, 1'b1);
                    end
                end else begin
                    n_state = ST_SCAN;
                end
            end

            ST_FETCH: begin
                n_state = ST_MODIFY;
            end

            ST_MODIFY: begin
                o_wr_en = 1'b1;
                n_stb   = 1'b1;
                n_rsp   = make_rsp(OC_UPDATED, r_idx, bumped, r_count, 1'b1);
                n_state = ST_IDLE;
            end

            ST_DUMP: begin
                if (r_idx < r_count) begin
                    n_idx     = r_idx + CW'(1);
                    n_cmp_idx = r_idx;
                    n_pend    = 1'b1;
                end
                if (r_pend) begin
                    n_stb = 1'b1;
                    n_rsp = make_rsp(OC_DUMP, r_cmp_idx, i_rd_data, r_count, dump_last);
                    if (dump_last) begin
                        n_state = ST_IDLE;
                        n_pend  = 1'b0;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_strobe = r_stb;
    assign o_rsp    = r_rsp;

endmodule

// ----- design/gossip_membership_table.sv -----
// top level of the gossip membership table
//
// A request is taken when start is high and busy is low. A merge walks the valid
// entries one per cycle through the single read port of the table memory until a key
// matches. Heartbeat and an in-range mark-offline are busy while they read, bump and
// write back one entry; an out-of-range mark-offline answers the cycle after start
// without going busy. A dump stays busy while it streams one entry per cycle.
// Each result shows on o_rsp for exactly one cycle with o_strobe high and cannot be
// held off; o_rsp.last marks the final result of a request. The local key register
// may be written through i_cfg_we at any time the block is idle.
module gossip_membership_table import gmt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    input  logic             i_cfg_we,
    input  logic [KEY_W-1:0] i_cfg_data,
    output logic             o_strobe,
    output t_rsp             o_rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [AW-1:0] rd_addr;
    t_entry        rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;

    gmt_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data)
    );

    gmt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_req      (i_req),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_strobe   (o_strobe),
        .o_rsp      (o_rsp)
    );

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_rsp.entry_count != '0) &&
                     (o_rsp.entry_count <= COUNT_W'(TABLE_DEPTH)))
        else $error("entry count out of range");

    a_full_only_at_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.outcome == OC_FULL) |->
            (o_rsp.entry_count == COUNT_W'(TABLE_DEPTH)))
        else $error("table full reported below depth");

    a_stream_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_rsp.last) |=> o_strobe)
        else $error("dump stream has a gap");

    a_done_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> (o_strobe && o_rsp.last))
        else $error("request finished without final result");
`endif

endmodule

// ----- bench/gmt_checker.sv -----
// result checker for the gossip membership table: mirrors the table and compares every result
module gmt_checker import gmt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  t_req             i_req,
    input  logic             i_cfg_we,
    input  logic [KEY_W-1:0] i_cfg_data,
    input  logic             o_strobe,
    input  t_rsp             o_rsp,
    output int               fail_count
);

    localparam int DEPTH = TABLE_DEPTH_DEF;

    logic [31:0] tbl_key [DEPTH];
    logic [31:0] tbl_gen [DEPTH];
    logic [31:0] tbl_ver [DEPTH];
    logic        tbl_online [DEPTH];
    int          live_count;
    t_rsp        owed_rsp [$];
    int          mismatches;

    // snapshot of one entry as the block should report it
    function automatic t_rsp report_entry(t_outcome oc, int slot, bit filled, bit fin);
        t_rsp r;
        r = '0;
        r.outcome = oc;
        if (filled) begin
            r.slot           = slot[SLOT_W-1:0];
            r.out_key        = tbl_key[slot];
            r.out_generation = tbl_gen[slot];
            r.out_version    = tbl_ver[slot];
            r.out_online     = tbl_online[slot];
        end
        r.entry_count = live_count[COUNT_W-1:0];
        r.last        = fin;
        return r;
    endfunction

    task automatic apply_request(input t_req r);
        int hit;
        hit = -1;
        case (t_action'(r.action))
            ACT_MERGE: begin
                // first matching key wins, entry 0 included
                for (int i = 0; i < live_count; i++) begin
                    if (hit < 0 && tbl_key[i] == r.host_key)
                        hit = i;
                end
                if (hit >= 0) begin
                    if (r.peer_generation > tbl_gen[hit] ||
                        (r.peer_generation == tbl_gen[hit] && r.peer_version > tbl_ver[hit])) begin
                        tbl_gen[hit]    = r.peer_generation;
                        tbl_ver[hit]    = r.peer_version;
                        tbl_online[hit] = r.peer_online;
                        owed_rsp.push_back(report_entry(OC_UPDATED, hit, 1'b1, 1'b1));
                    end else begin
                        owed_rsp.push_back(report_entry(OC_IGNORED, hit, 1'b1, 1'b1));
                    end
                end else if (live_count < DEPTH) begin
                    tbl_key[live_count]    = r.host_key;
                    tbl_gen[live_count]    = r.peer_generation;
                    tbl_ver[live_count]    = r.peer_version;
                    tbl_online[live_count] = r.peer_online;
                    live_count++;
                    owed_rsp.push_back(report_entry(OC_INSERTED, live_count - 1, 1'b1, 1'b1));
                end else begin
                    owed_rsp.push_back(report_entry(OC_FULL, 0, 1'b0, 1'b1));
                end
            end
            ACT_HEARTBEAT: begin
                tbl_online[0] = 1'b1;
                tbl_ver[0]    = tbl_ver[0] + 32'd1;
                owed_rsp.push_back(report_entry(OC_UPDATED, 0, 1'b1, 1'b1));
            end
            ACT_OFFLINE: begin
                if (int'(r.entry_index) < live_count) begin
                    tbl_online[r.entry_index] = 1'b0;
                    tbl_ver[r.entry_index]    = tbl_ver[r.entry_index] + 32'd1;
                    owed_rsp.push_back(report_entry(OC_UPDATED, int'(r.entry_index), 1'b1,
                                                    1'b1));
                end else begin
                    owed_rsp.push_back(report_entry(OC_BAD_INDEX, 0, 1'b0, 1'b1));
                end
            end
            default: begin
                for (int i = 0; i < live_count; i++)
                    owed_rsp.push_back(report_entry(OC_DUMP, i, 1'b1, i == live_count - 1));
            end
        endcase
    endtask

    task automatic cmp_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                tbl_key[i]    = '0;
                tbl_gen[i]    = '0;
                tbl_ver[i]    = '0;
                tbl_online[i] = 1'b0;
            end
            tbl_gen[0]    = 32'd1;
            tbl_ver[0]    = 32'd1;
            tbl_online[0] = 1'b1;
            live_count    = 1;
            owed_rsp.delete();
        end else begin
            if (o_strobe) begin
                if (owed_rsp.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got %h", $time, o_rsp);
                end else begin
                    want = owed_rsp.pop_front();
                    cmp_field("outcome", 32'(want.outcome), 32'(o_rsp.outcome));
                    cmp_field("slot", 32'(want.slot), 32'(o_rsp.slot));
                    cmp_field("out_key", want.out_key, o_rsp.out_key);
                    cmp_field("out_generation", want.out_generation, o_rsp.out_generation);
                    cmp_field("out_version", want.out_version, o_rsp.out_version);
                    cmp_field("out_online", 32'(want.out_online), 32'(o_rsp.out_online));
                    cmp_field("entry_count", 32'(want.entry_count), 32'(o_rsp.entry_count));
                    cmp_field("last", 32'(want.last), 32'(o_rsp.last));
                end
            end
            if (i_cfg_we)
                tbl_key[0] = i_cfg_data;
            if (start && !busy)
                apply_request(i_req);
        end
        // results still owed count against the run
        fail_count <= mismatches + owed_rsp.size();
    end

endmodule

// ----- bench/tb_top.sv -----
// testbench top for the gossip membership table: request stimulus and verdict
module tb_top;
    import gmt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_req             i_req;
    logic             i_cfg_we;
    logic [KEY_W-1:0] i_cfg_data;
    logic             o_strobe;
    t_rsp             o_rsp;

    int          fail_count;
    int          taken_cnt;
    int          closed_cnt;
    int          cycle_cnt;
    bit          no_gaps;
    logic [31:0] key_pool [$];

    gossip_membership_table u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_rsp      (o_rsp)
    );

    gmt_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_rsp      (o_rsp),
        .fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && o_strobe && o_rsp.last)
            closed_cnt <= closed_cnt + 1;
    end

    function automatic t_req build(t_action a, logic [31:0] k, logic [31:0] g, logic [31:0] v,
                                   logic o, logic [SLOT_W-1:0] idx);
        t_req r;
        r.action          = a;
        r.host_key        = k;
        r.peer_generation = g;
        r.peer_version    = v;
        r.peer_online     = o;
        r.entry_index     = idx;
        return r;
    endfunction

    // generation or version: mostly small or near the top so compares go both ways
    function automatic logic [31:0] rand_stamp();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return $urandom_range(0, 3);
        else if (pick < 70)
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
        else
            return $urandom;
    endfunction

    task automatic send_request(input t_req r);
        int gap;
        int pick;
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        taken_cnt++;
        @(negedge i_clk);
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 50)
            gap = 0;
        else if (pick < 85)
            gap = $urandom_range(1, 3);
        else if (pick < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // wait until every request has closed, then let the block settle
    task automatic drain();
        start <= 1'b0;
        while (closed_cnt != taken_cnt) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_local_key(input logic [31:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        key_pool.push_back(v);
    endtask

    task automatic random_phase(input int n, input int fresh_pct);
        t_req r;
        int   pick;
        int   top_idx;
        repeat (n) begin
            r = build(ACT_MERGE, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                      6'($urandom_range(0, 63)));
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                if (key_pool.size() == 0 || $urandom_range(0, 99) < fresh_pct)
                    key_pool.push_back(r.host_key);
                else
                    r.host_key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                r.peer_generation = rand_stamp();
                r.peer_version    = rand_stamp();
            end else if (pick < 70) begin
                r.action = ACT_HEARTBEAT;
            end else if (pick < 90) begin
                r.action = ACT_OFFLINE;
                // half the indexes drawn from zero up to the likely fill level
                top_idx = (key_pool.size() > 63) ? 63 : key_pool.size();
                if ($urandom_range(0, 1))
                    r.entry_index = 6'($urandom_range(0, top_idx));
            end else begin
                r.action = ACT_DUMP;
            end
            send_request(r);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        no_gaps    = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_local_key(32'h0);
        send_request(build(ACT_DUMP, 32'h0, 32'h0, 32'h0, 1'b0, 6'd0));
        send_request(build(ACT_HEARTBEAT, 32'h0, 32'h0, 32'h0, 1'b0, 6'd0));
        // merges against the local entry: stale, then newer with the top version
        send_request(build(ACT_MERGE, 32'h0, 32'd1, 32'd0, 1'b1, 6'd0));
        send_request(build(ACT_MERGE, 32'h0, 32'd1, 32'hFFFF_FFFF, 1'b0, 6'd0));
        // version wraps to zero
        send_request(build(ACT_HEARTBEAT, 32'h0, 32'h0, 32'h0, 1'b0, 6'd63));
        send_request(build(ACT_MERGE, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 6'd0));
        send_request(build(ACT_MERGE, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 6'd0));
        send_request(build(ACT_MERGE, 32'hFFFF_FFFF, 32'h0, 32'd1, 1'b0, 6'd0));
        send_request(build(ACT_MERGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 6'd0));
        send_request(build(ACT_MERGE, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0,
                           6'd0));
        send_request(build(ACT_MERGE, 32'hA5A5_5A5A, 32'd5, 32'hFFFF_FFFF, 1'b1, 6'd0));
        send_request(build(ACT_OFFLINE, 32'h0, 32'h0, 32'h0, 1'b0, 6'd2));
        send_request(build(ACT_OFFLINE, 32'h0, 32'h0, 32'h0, 1'b0, 6'd0));
        send_request(build(ACT_OFFLINE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                           6'd3));
        send_request(build(ACT_OFFLINE, 32'h0, 32'h0, 32'h0, 1'b0, 6'd63));
        send_request(build(ACT_HEARTBEAT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                           6'd63));
        send_request(build(ACT_DUMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                           6'd63));
        key_pool.push_back(32'hA5A5_5A5A);

        // new local key now shadows the copy stored at slot 1
        write_local_key(32'hFFFF_FFFF);
        send_request(build(ACT_MERGE, 32'h0, 32'd7, 32'd7, 1'b1, 6'd0));
        send_request(build(ACT_MERGE, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 6'd0));
        send_request(build(ACT_MERGE, 32'hFFFF_FFFF, 32'd2, 32'h0, 1'b0, 6'd0));
        send_request(build(ACT_DUMP, 32'h0, 32'h0, 32'h0, 1'b0, 6'd0));

        write_local_key($urandom);
        random_phase(70, 25);
        no_gaps = 1'b1;
        random_phase(40, 25);
        no_gaps = 1'b0;
        write_local_key(32'h0);
        random_phase(130, 40);

        // fill the table to the top and push past it
        repeat (64) begin
            key_pool.push_back($urandom);
            send_request(build(ACT_MERGE, key_pool[key_pool.size() - 1], rand_stamp(),
                               rand_stamp(), 1'($urandom_range(0, 1)),
                               6'($urandom_range(0, 63))));
        end
        send_request(build(ACT_OFFLINE, 32'h0, 32'h0, 32'h0, 1'b0, 6'd63));
        random_phase(12, 30);
        send_request(build(ACT_DUMP, 32'h0, 32'h0, 32'h0, 1'b0, 6'd0));

        drain();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/gmt_pkg.sv
design/gmt_store.sv
design/gmt_ctrl.sv
design/gossip_membership_table.sv
bench/gmt_checker.sv
bench/tb_top.sv
